/* hdl/lzwd_pkg.sv */
// Shared types and constants of the LZ77 window decompressor.
package lzwd_pkg;

	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;
	localparam int LEN_BIAS  = 3;
	localparam int MAX_COPY  = 18;

	localparam int CNT_W  = 5;
	localparam int DIST_W = 12;

	typedef struct packed {
		logic              is_copy;
		logic [7:0]        lit;
		logic [DIST_W-1:0] copy_dist;
		logic [CNT_W-1:0]  count;
		logic              done;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} res_t;

endpackage

/* hdl/lzwd_fifo.sv */
// Small register FIFO with a push/full and pop/empty interface.
module lzwd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("FIFO count exceeds its depth");

endmodule

/* hdl/lzwd_front.sv */
// Stream parser: header, flag bytes and tokens turned into literal and copy commands.
module lzwd_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_write,
	input  logic         cfg_data,
	input  logic         push,
	output logic         full,
	input  logic [7:0]   in_byte,
	input  logic         stream_start,
	output logic         cmd_push,
	output lzwd_pkg::cmd_t cmd,
	input  logic         cmd_full
);

	localparam logic [2:0] PH_HEADER    = 3'd0;
	localparam logic [2:0] PH_FLAG      = 3'd1;
	localparam logic [2:0] PH_ITEM      = 3'd2;
	localparam logic [2:0] PH_TOKEN_LOW = 3'd3;
	localparam logic [2:0] PH_DONE      = 3'd4;

	logic        has_header_q;
	logic [2:0]  phase_q;
	logic [2:0]  hcount_q;
	logic [23:0] rem_q;
	logic [7:0]  flags_q;
	logic [2:0]  fidx_q;
	logic [7:0]  thigh_q;

	logic [2:0]  e_phase, phase_d;
	logic [2:0]  e_hcount, hcount_d;
	logic [23:0] e_rem, rem_d;
	logic [7:0]  e_flags, flags_d;
	logic [2:0]  e_fidx, fidx_d;
	logic [7:0]  e_thigh, thigh_d;

	logic        accept;
	logic [3:0]  hsum;
	logic [3:0]  htotal;
	logic [3:0]  hpos4;
	logic [1:0]  hpos;
	logic [23:0] hrem;
	logic [4:0]  tlen;
	logic [4:0]  tcount;
	logic        tdone;
	logic        ldone;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	always_comb begin
		e_phase  = phase_q;
		e_hcount = hcount_q;
		e_rem    = rem_q;
		e_flags  = flags_q;
		e_fidx   = fidx_q;
		e_thigh  = thigh_q;
		if (stream_start) begin
			e_phase  = PH_HEADER;
			e_hcount = '0;
			e_rem    = '0;
			e_flags  = '0;
			e_fidx   = '0;
			e_thigh  = '0;
		end
	end

	always_comb begin
		hsum   = {1'b0, e_hcount} + 4'(lzwd_pkg::LEN_BIAS);
		htotal = has_header_q ? 4'd8 : 4'd4;
		hpos4  = hsum - htotal;
		hpos   = (hpos4 > 4'd2) ? 2'd2 : hpos4[1:0];
		hrem   = e_rem;
		case (hpos)
			2'd0:    hrem[7:0]   = in_byte;
			2'd1:    hrem[15:8]  = in_byte;
			default: hrem[23:16] = in_byte;
		endcase
		tlen   = 5'(e_thigh[7:4]) + 5'(lzwd_pkg::LEN_BIAS);
		tdone  = (e_rem <= 24'(tlen));
		tcount = tdone ? e_rem[4:0] : tlen;
		ldone  = (e_rem <= 24'd1);
	end

	always_comb begin
		phase_d       = e_phase;
		hcount_d      = e_hcount;
		rem_d         = e_rem;
		flags_d       = e_flags;
		fidx_d        = e_fidx;
		thigh_d       = e_thigh;
		cmd_push      = 1'b0;
		cmd.is_copy   = 1'b0;
		cmd.lit       = in_byte;
		cmd.copy_dist = {e_thigh[3:0], in_byte};
		cmd.count     = 5'd1;
		cmd.done      = ldone;
		case (e_phase)
			PH_HEADER: begin
				hcount_d = e_hcount + 3'd1;
				if (hsum >= htotal) begin
					rem_d = hrem;
					if (hpos == 2'd2) begin
						hcount_d = '0;
						fidx_d   = '0;
						phase_d  = (hrem == '0) ? PH_DONE : PH_FLAG;
					end
				end
			end
			PH_FLAG: begin
				flags_d = in_byte;
				fidx_d  = '0;
				phase_d = PH_ITEM;
			end
			PH_ITEM: begin
				if (e_flags[3'd7 - e_fidx]) begin
					thigh_d = in_byte;
					phase_d = PH_TOKEN_LOW;
				end else begin
					cmd_push = accept;
					rem_d    = (e_rem == '0) ? '0 : e_rem - 24'd1;
					if (ldone) begin
						phase_d = PH_DONE;
					end else if (e_fidx == 3'd7) begin
						fidx_d  = '0;
						phase_d = PH_FLAG;
					end else begin
						fidx_d  = e_fidx + 3'd1;
						phase_d = PH_ITEM;
					end
				end
			end
			PH_TOKEN_LOW: begin
				cmd_push    = accept;
				cmd.is_copy = 1'b1;
				cmd.count   = tcount;
				cmd.done    = tdone;
				rem_d       = e_rem - 24'(tcount);
				if (tdone) begin
					phase_d = PH_DONE;
				end else if (e_fidx == 3'd7) begin
					fidx_d  = '0;
					phase_d = PH_FLAG;
				end else begin
					fidx_d  = e_fidx + 3'd1;
					phase_d = PH_ITEM;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_header_q <= 1'b0;
			phase_q      <= PH_HEADER;
			hcount_q     <= '0;
			rem_q        <= '0;
			flags_q      <= '0;
			fidx_q       <= '0;
			thigh_q      <= '0;
		end else begin
			if (cfg_write) begin
				has_header_q <= cfg_data;
			end
			if (accept) begin
				phase_q  <= phase_d;
				hcount_q <= hcount_d;
				rem_q    <= rem_d;
				flags_q  <= flags_d;
				fidx_q   <= fidx_d;
				thigh_q  <= thigh_d;
			end
		end
	end

	a_cmd_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (cmd.count != '0) && (cmd.count <= 5'(lzwd_pkg::MAX_COPY)))
		else $error("Command carries an impossible byte count");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) && !(push && !cmd_full && stream_start) |=> !cmd_push
			|| stream_start)
		else $error("Command issued after the stream ended");

endmodule

/* hdl/lzwd_back.sv */
// Command executor: history window, copy engine and result generation.
module lzwd_back #(
	parameter int WINDOW_DEPTH = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lzwd_pkg::cmd_t cmd_head,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	output logic           res_push,
	output lzwd_pkg::res_t res,
	input  logic           res_full
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam logic [AW:0] DEPTH_W  = (AW + 1)'(WINDOW_DEPTH);
	localparam logic [AW:0] DEPTH_M1 = (AW + 1)'(WINDOW_DEPTH - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_COPY = 1'b1;

	logic [7:0] mem [WINDOW_DEPTH];

	logic          state_q, state_d;
	logic [AW-1:0] wp_q, wp_d;
	logic          wrapped_q, wrapped_d;
	logic [AW-1:0] rp_q, rp_d;
	logic [4:0]    left_q, left_d;
	logic          done_q, done_d;
	logic [7:0]    rmem_q;
	logic          fwd_q;
	logic [7:0]    fwd_byte_q;
	logic          zero_q;

	logic          we;
	logic [7:0]    wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [AW:0]   rtmp;
	logic [AW-1:0] rd0;
	logic [AW-1:0] rd0_next;
	logic [AW-1:0] rp_next;
	logic [7:0]    rbyte;

	always_comb begin
		rtmp     = {1'b0, wp_q} + DEPTH_M1 - (AW + 1)'(cmd_head.copy_dist);
		rd0      = (rtmp >= DEPTH_W) ? AW'(rtmp - DEPTH_W) : AW'(rtmp);
		rd0_next = (rd0 == LAST_ADDR) ? '0 : rd0 + 1'b1;
		rp_next  = (rp_q == LAST_ADDR) ? '0 : rp_q + 1'b1;
		rbyte    = fwd_q ? fwd_byte_q : (zero_q ? 8'h00 : rmem_q);
	end

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		wrapped_d = wrapped_q;
		rp_d      = rp_q;
		left_d    = left_q;
		done_d    = done_q;
		cmd_pop   = 1'b0;
		we        = 1'b0;
		wdata     = cmd_head.lit;
		re        = 1'b0;
		raddr     = rd0;
		res_push  = 1'b0;
		res.data  = cmd_head.lit;
		res.last  = 1'b1;
		res.done  = cmd_head.done;
		case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					if (cmd_head.is_copy) begin
						cmd_pop = 1'b1;
						re      = 1'b1;
						raddr   = rd0;
						rp_d    = rd0_next;
						left_d  = cmd_head.count;
						done_d  = cmd_head.done;
						state_d = S_COPY;
					end else if (!res_full) begin
						cmd_pop  = 1'b1;
						we       = 1'b1;
						res_push = 1'b1;
					end
				end
			end
			S_COPY: begin
				wdata    = rbyte;
				res.data = rbyte;
				res.last = (left_q == 5'd1);
				res.done = done_q && (left_q == 5'd1);
				raddr    = rp_q;
				if (!res_full) begin
					we       = 1'b1;
					res_push = 1'b1;
					left_d   = left_q - 5'd1;
					if (left_q == 5'd1) begin
						state_d = S_IDLE;
					end else begin
						re   = 1'b1;
						rp_d = rp_next;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (we) begin
			wp_d = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
			if (wp_q == LAST_ADDR) begin
				wrapped_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rmem_q <= mem[raddr];
		end
	end

	// Entries never written since reset read as zero; a same-cycle write is forwarded.
	always_ff @(posedge clk) begin
		if (re) begin
			fwd_q      <= we && (raddr == wp_q);
			fwd_byte_q <= wdata;
			zero_q     <= !wrapped_q && (raddr >= wp_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			rp_q      <= '0;
			left_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			wp_q      <= wp_d;
			wrapped_q <= wrapped_d;
			rp_q      <= rp_d;
			left_q    <= left_d;
			done_q    <= done_d;
		end
	end

	a_copy_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> (left_q != '0) && (left_q <= 5'(lzwd_pkg::MAX_COPY)))
		else $error("Copy running with an impossible byte count");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("Result pushed into a full queue");

	a_wrapped_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(wrapped_q) |-> wrapped_q)
		else $error("Window wrap mark cleared outside reset");

	a_write_advance: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (wp_q != $past(wp_q)))
		else $error("Window pointer did not advance with a result");

endmodule

/* hdl/lz77_window_decompressor.sv */
// LZ77 type-0x10 stream decompressor with a sliding history window.
//
// Compressed bytes enter on push/full: a byte is taken at a clock edge with push high and
// full low, stream_start marking the first byte of a new stream. Decompressed bytes leave
// on empty/pop: the oldest result sits on out_byte, last_of_run and stream_done while
// empty is low and is taken at an edge with pop high. has_header is written through
// cfg_write/cfg_data; the user must write it only while the block is idle, which the block itself does not enforce.
// The parser classifies one byte per cycle while the command queue is not full and hands
// literal and copy commands to the window engine through a four-entry queue. A literal passes
// straight through the engine; a copy of up to 18 bytes holds it until its last byte, each read
// through the single window read port; header and flag bytes cost the engine nothing. A literal
// reaches the result ports via the command and result queues, a copy byte also via the window
// read register, so one token of two input bytes can hold the engine for a whole copy.
// After reset the window reads as zeros: the engine tracks which entries have been written
// since reset, so no clearing pass is needed and the block is ready at once.
// When the receiver stops popping, the result queue fills, the engine halts, the command
// queue fills and full rises; nothing is dropped.
module lz77_window_decompressor #(
	parameter int WINDOW_DEPTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       stream_start,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       stream_done
);

	localparam int CMD_W = $bits(lzwd_pkg::cmd_t);
	localparam int RES_W = $bits(lzwd_pkg::res_t);

	logic             cmd_push;
	lzwd_pkg::cmd_t   cmd_in;
	logic             cmd_full;
	logic             cmd_pop;
	logic             cmd_empty;
	logic [CMD_W-1:0] cmd_vec;
	lzwd_pkg::cmd_t   cmd_head;
	logic             res_push;
	lzwd_pkg::res_t   res_in;
	logic             res_full;
	logic [RES_W-1:0] res_vec;
	lzwd_pkg::res_t   res_head;

	assign cmd_head    = lzwd_pkg::cmd_t'(cmd_vec);
	assign res_head    = lzwd_pkg::res_t'(res_vec);
	assign out_byte    = res_head.data;
	assign last_of_run = res_head.last;
	assign stream_done = res_head.done;

	lzwd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.stream_start (stream_start),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in),
		.cmd_full     (cmd_full)
	);

	lzwd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (lzwd_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_vec),
		.empty  (cmd_empty)
	);

	lzwd_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_head  (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	lzwd_fifo #(
		.WIDTH (RES_W),
		.DEPTH (lzwd_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_vec),
		.empty  (empty)
	);

endmodule
